/* rtl/ide_pio_sector_read_sequencer_assert.svh */
// Assertion macros shared by the sequencer RTL.
`ifndef IDE_PIO_SECTOR_READ_SEQUENCER_ASSERT_SVH
`define IDE_PIO_SECTOR_READ_SEQUENCER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define IPSR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion lbl failed");
`define IPSR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion lbl failed");
`else
`define IPSR_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define IPSR_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* rtl/ipsr_pkg.sv */
// Types and constants of the IDE PIO sector read sequencer.
package ipsr_pkg;

  localparam int WORDS_PER_SECTOR = 256;
  localparam int WORD_CNT_W = $clog2(WORDS_PER_SECTOR + 1);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_HOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEV_BASE   = 2'd2;

  localparam logic [7:0] RST_POLL_LIMIT = 8'd255;
  localparam logic [7:0] RST_RESET_HOLD = 8'd255;
  localparam logic [7:0] RST_DEV_BASE   = 8'hA0;

  // Input transaction kinds.
  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_READ = 2'd1;
  localparam logic [1:0] KIND_INIT = 2'd2;

  // Control line patterns: bits 2:0 address, 3 cs0, 4 cs1, 5 write, 6 read, 7 reset.
  localparam logic [7:0] CTRL_COUNT   = 8'h0A;
  localparam logic [7:0] CTRL_SECTOR  = 8'h0B;
  localparam logic [7:0] CTRL_CYL_LO  = 8'h0C;
  localparam logic [7:0] CTRL_CYL_HI  = 8'h0D;
  localparam logic [7:0] CTRL_HEADDEV = 8'h0E;
  localparam logic [7:0] CTRL_STATUS  = 8'h0F;
  localparam logic [7:0] CTRL_DATA    = 8'h08;
  localparam logic [7:0] LINE_WR      = 8'h20;
  localparam logic [7:0] LINE_RD      = 8'h40;
  localparam logic [7:0] LINE_RST     = 8'h80;

  localparam logic [7:0] CMD_READ_SECTOR = 8'h20;
  localparam logic [7:0] SECTOR_COUNT    = 8'h01;

  // Status bit masks and expected values.
  localparam logic [7:0] STAT_BSY_MASK = 8'h80;
  localparam logic [7:0] STAT_RDY_MASK = 8'hC0;
  localparam logic [7:0] STAT_RDY_OK   = 8'h40;
  localparam logic [7:0] STAT_DRQ_MASK = 8'h88;
  localparam logic [7:0] STAT_DRQ_OK   = 8'h08;
  localparam logic [7:0] STAT_ERR_MASK = 8'h01;

  // Completion codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BUSY_TO   = 2'd1;
  localparam logic [1:0] ST_DRQ_TO    = 2'd2;
  localparam logic [1:0] ST_DRIVE_ERR = 2'd3;

  typedef struct packed {
    logic [7:0] poll_limit;
    logic [7:0] reset_hold_ticks;
    logic [7:0] device_select_base;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  ctrl_lines;
    logic [7:0]  drive_data;
    logic        drive_enable;
    logic [15:0] word;
    logic        word_valid;
    logic        word_last;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  status;
  } res_t;

endpackage

/* rtl/ipsr_if.sv */
// Channel interfaces of the IDE PIO sector read sequencer.
interface ipsr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] sector;
  logic [3:0] head;
  logic [7:0] cyl_low;
  logic [7:0] cyl_high;
  logic [7:0] bus_low;
  logic [7:0] bus_high;

  modport source(output valid, kind, sector, head, cyl_low, cyl_high, bus_low, bus_high,
                 input ready);
  modport sink(input valid, kind, sector, head, cyl_low, cyl_high, bus_low, bus_high,
               output ready);
endinterface

interface ipsr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  ctrl_lines;
  logic [7:0]  drive_data;
  logic        drive_enable;
  logic [15:0] word;
  logic        word_valid;
  logic        word_last;
  logic        busy_res;
  logic        done_res;
  logic [1:0]  status;

  modport source(output valid, ctrl_lines, drive_data, drive_enable, word, word_valid,
                 word_last, busy_res, done_res, status, input ready);
  modport sink(input valid, ctrl_lines, drive_data, drive_enable, word, word_valid,
               word_last, busy_res, done_res, status, output ready);
endinterface

interface ipsr_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* rtl/ipsr_cfg.sv */
// Configuration register bank of the sequencer.
module ipsr_cfg (
  input  logic            clk,
  input  logic            rst,
  ipsr_cfg_if.sink        cfg,
  output ipsr_pkg::cfg_t  regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.poll_limit         <= ipsr_pkg::RST_POLL_LIMIT;
      regs.reset_hold_ticks   <= ipsr_pkg::RST_RESET_HOLD;
      regs.device_select_base <= ipsr_pkg::RST_DEV_BASE;
    end else if (cfg.valid) begin
      case (cfg.index)
        ipsr_pkg::CFG_POLL_LIMIT: regs.poll_limit         <= cfg.data;
        ipsr_pkg::CFG_RESET_HOLD: regs.reset_hold_ticks   <= cfg.data;
        ipsr_pkg::CFG_DEV_BASE:   regs.device_select_base <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/ide_pio_sector_read_sequencer.sv */
// A result is registered: it appears in the cycle after its input transaction is accepted.
// Throughput: one transaction per cycle; the sequencer state and the result
// register update in the same cycle, so the only stall is a full result register.
// A sector read spans 30 + 4 * (ready polls + DRQ polls) + 2 * WORDS_PER_SECTOR transactions.
// Synchronous reset returns to idle and loads the register reset values.
`include "ide_pio_sector_read_sequencer_assert.svh"

module ide_pio_sector_read_sequencer (
  input logic        clk,
  input logic        rst,
  ipsr_in_if.sink    item,
  ipsr_out_if.source result,
  ipsr_cfg_if.sink   cfg
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_INIT_HOLD, PH_INIT_SHD, PH_INIT_POLL, PH_RD_REGS, PH_RD_POLL_RDY,
    PH_RD_CMD, PH_RD_POLL_DRQ, PH_RD_DATA, PH_RD_ERRCHK, PH_END_OK, PH_END_BUSY_TO,
    PH_END_DRQ_TO, PH_END_DRIVE_ERR, PH_GO_CMD, PH_GO_DATA
  } phase_t;

  localparam int WCW = ipsr_pkg::WORD_CNT_W;

  ipsr_pkg::cfg_t regs;

  phase_t          phase, phase_next;
  logic [1:0]      strobe_step, strobe_next;
  logic [2:0]      register_index, register_index_next;
  logic [7:0]      poll_counter, poll_counter_next;
  logic [WCW-1:0]  word_counter, word_counter_next;
  logic [7:0]      sector_latch, sector_latch_next;
  logic [3:0]      head_latch, head_latch_next;
  logic [7:0]      cyl_low_latch, cyl_low_latch_next;
  logic [7:0]      cyl_high_latch, cyl_high_latch_next;

  ipsr_pkg::res_t  res, res_next;
  logic            res_valid;
  logic            accept;

  // Working values after a possible start in the idle phase.
  phase_t          ph_cur;
  logic [1:0]      st_cur;
  logic [2:0]      ri_cur;
  logic [7:0]      pc_cur;

  logic            do_write;
  logic [7:0]      wr_reg, wr_val;
  logic            wr_last;
  logic            do_poll, poll_ok;
  phase_t          poll_ok_ph, poll_fail_ph;
  logic [7:0]      poll_lim, poll_lim_eff, hold_eff;
  logic [8:0]      pc_inc;
  logic [WCW:0]    wc_inc;

  ipsr_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  assign accept       = item.valid && item.ready;
  assign item.ready   = !res_valid || result.ready;

  always_comb begin
    phase_next          = phase;
    register_index_next = register_index;
    word_counter_next   = word_counter;
    sector_latch_next   = sector_latch;
    head_latch_next     = head_latch;
    cyl_low_latch_next  = cyl_low_latch;
    cyl_high_latch_next = cyl_high_latch;
    res_next            = '0;
    res_next.busy_res   = 1'b1;
    do_write            = 1'b0;
    wr_reg              = '0;
    wr_val              = '0;
    do_poll             = 1'b0;
    poll_ok             = 1'b0;
    poll_ok_ph          = PH_END_OK;
    poll_fail_ph        = PH_END_BUSY_TO;
    poll_lim            = regs.poll_limit;

    ph_cur = phase;
    st_cur = strobe_step;
    ri_cur = register_index;
    pc_cur = poll_counter;
    if (phase == PH_IDLE) begin
      if (item.kind == ipsr_pkg::KIND_READ) begin
        sector_latch_next   = item.sector;
        head_latch_next     = item.head;
        cyl_low_latch_next  = item.cyl_low;
        cyl_high_latch_next = item.cyl_high;
        ph_cur = PH_RD_REGS;
        ri_cur = '0;
        st_cur = '0;
      end else if (item.kind == ipsr_pkg::KIND_INIT) begin
        ph_cur = PH_INIT_HOLD;
        pc_cur = '0;
        st_cur = '0;
      end
    end
    phase_next          = ph_cur;
    strobe_next         = st_cur;
    register_index_next = ri_cur;
    poll_counter_next   = pc_cur;
    wr_last             = (st_cur == 2'd3);
    pc_inc              = {1'b0, pc_cur} + 9'd1;
    wc_inc              = {1'b0, word_counter} + {{WCW{1'b0}}, 1'b1};
    hold_eff            = (regs.reset_hold_ticks == '0) ? 8'd1 : regs.reset_hold_ticks;

    case (ph_cur)
      PH_INIT_HOLD: begin
        res_next.ctrl_lines = ipsr_pkg::LINE_RST;
        poll_counter_next   = pc_inc[7:0];
        if (pc_inc[7:0] >= hold_eff) begin
          phase_next        = PH_INIT_SHD;
          poll_counter_next = '0;
          strobe_next       = '0;
        end
      end
      PH_INIT_SHD: begin
        do_write = 1'b1;
        wr_reg   = ipsr_pkg::CTRL_HEADDEV;
        wr_val   = regs.device_select_base;
        if (wr_last) begin
          phase_next        = PH_INIT_POLL;
          poll_counter_next = '0;
        end
      end
      PH_INIT_POLL: begin
        do_poll      = 1'b1;
        poll_ok      = (item.bus_low & ipsr_pkg::STAT_BSY_MASK) == '0;
        poll_ok_ph   = PH_END_OK;
        poll_fail_ph = PH_END_BUSY_TO;
      end
      PH_RD_REGS: begin
        do_write = 1'b1;
        case (ri_cur)
          3'd0: begin
            wr_reg = ipsr_pkg::CTRL_SECTOR;
            wr_val = sector_latch_next;
          end
          3'd1: begin
            wr_reg = ipsr_pkg::CTRL_HEADDEV;
            wr_val = regs.device_select_base | {4'd0, head_latch_next};
          end
          3'd2: begin
            wr_reg = ipsr_pkg::CTRL_CYL_LO;
            wr_val = cyl_low_latch_next;
          end
          3'd3: begin
            wr_reg = ipsr_pkg::CTRL_CYL_HI;
            wr_val = cyl_high_latch_next;
          end
          default: begin
            wr_reg = ipsr_pkg::CTRL_COUNT;
            wr_val = ipsr_pkg::SECTOR_COUNT;
          end
        endcase
        if (wr_last) begin
          if (ri_cur >= 3'd4) begin
            phase_next          = PH_RD_POLL_RDY;
            poll_counter_next   = '0;
            register_index_next = '0;
          end else begin
            register_index_next = ri_cur + 3'd1;
          end
        end
      end
      PH_RD_POLL_RDY: begin
        do_poll      = 1'b1;
        poll_ok      = (item.bus_low & ipsr_pkg::STAT_RDY_MASK) == ipsr_pkg::STAT_RDY_OK;
        poll_ok_ph   = PH_GO_CMD;
        poll_fail_ph = PH_END_BUSY_TO;
      end
      PH_RD_CMD: begin
        do_write = 1'b1;
        wr_reg   = ipsr_pkg::CTRL_STATUS;
        wr_val   = ipsr_pkg::CMD_READ_SECTOR;
        if (wr_last) begin
          phase_next        = PH_RD_POLL_DRQ;
          poll_counter_next = '0;
        end
      end
      PH_RD_POLL_DRQ: begin
        do_poll      = 1'b1;
        poll_ok      = (item.bus_low & ipsr_pkg::STAT_DRQ_MASK) == ipsr_pkg::STAT_DRQ_OK;
        poll_ok_ph   = PH_GO_DATA;
        poll_fail_ph = PH_END_DRQ_TO;
      end
      PH_RD_DATA: begin
        case (st_cur)
          2'd0: begin
            res_next.ctrl_lines = ipsr_pkg::CTRL_DATA;
            strobe_next         = 2'd1;
          end
          2'd1: begin
            res_next.ctrl_lines = ipsr_pkg::CTRL_DATA | ipsr_pkg::LINE_RD;
            res_next.word       = {item.bus_high, item.bus_low};
            res_next.word_valid = 1'b1;
            if (wc_inc >= (WCW+1)'(ipsr_pkg::WORDS_PER_SECTOR)) begin
              res_next.word_last = 1'b1;
              strobe_next        = 2'd2;
            end else begin
              word_counter_next = wc_inc[WCW-1:0];
              strobe_next       = 2'd0;
            end
          end
          2'd2: begin
            res_next.ctrl_lines = ipsr_pkg::CTRL_DATA;
            strobe_next         = 2'd3;
          end
          default: begin
            strobe_next       = 2'd0;
            phase_next        = PH_RD_ERRCHK;
            poll_counter_next = '0;
          end
        endcase
      end
      PH_RD_ERRCHK: begin
        // A single status read decides the outcome: no retry.
        do_poll      = 1'b1;
        poll_ok      = (item.bus_low & ipsr_pkg::STAT_ERR_MASK) == '0;
        poll_ok_ph   = PH_END_OK;
        poll_fail_ph = PH_END_DRIVE_ERR;
        poll_lim     = 8'd1;
      end
      PH_END_OK, PH_END_BUSY_TO, PH_END_DRQ_TO, PH_END_DRIVE_ERR, PH_GO_CMD,
      PH_GO_DATA: begin
        // The status read that decided the branch still has strobe steps 2 and 3 to finish.
        if (st_cur == 2'd2) begin
          res_next.ctrl_lines = ipsr_pkg::CTRL_STATUS;
          strobe_next         = 2'd3;
        end else begin
          strobe_next = 2'd0;
          if (ph_cur == PH_GO_CMD) begin
            phase_next = PH_RD_CMD;
          end else if (ph_cur == PH_GO_DATA) begin
            phase_next        = PH_RD_DATA;
            word_counter_next = '0;
          end else begin
            case (ph_cur)
              PH_END_BUSY_TO:   res_next.status = ipsr_pkg::ST_BUSY_TO;
              PH_END_DRQ_TO:    res_next.status = ipsr_pkg::ST_DRQ_TO;
              PH_END_DRIVE_ERR: res_next.status = ipsr_pkg::ST_DRIVE_ERR;
              default:          res_next.status = ipsr_pkg::ST_OK;
            endcase
            res_next.busy_res = 1'b0;
            res_next.done_res = 1'b1;
            phase_next        = PH_IDLE;
          end
        end
      end
      default: begin
        phase_next        = PH_IDLE;
        res_next.busy_res = 1'b0;
      end
    endcase

    if (do_write) begin
      res_next.drive_enable = 1'b1;
      res_next.drive_data   = wr_val;
      case (st_cur)
        2'd1:    res_next.ctrl_lines = wr_reg | ipsr_pkg::LINE_WR;
        2'd3:    res_next.ctrl_lines = '0;
        default: res_next.ctrl_lines = wr_reg;
      endcase
      strobe_next = wr_last ? 2'd0 : st_cur + 2'd1;
    end

    poll_lim_eff = (poll_lim == '0) ? 8'd1 : poll_lim;
    if (do_poll) begin
      case (st_cur)
        2'd0: begin
          res_next.ctrl_lines = ipsr_pkg::CTRL_STATUS;
          strobe_next         = 2'd1;
        end
        2'd1: begin
          res_next.ctrl_lines = ipsr_pkg::CTRL_STATUS | ipsr_pkg::LINE_RD;
          strobe_next         = 2'd2;
          if (poll_ok) begin
            phase_next = poll_ok_ph;
          end else if (pc_inc >= {1'b0, poll_lim_eff}) begin
            phase_next = poll_fail_ph;
          end
        end
        2'd2: begin
          res_next.ctrl_lines = ipsr_pkg::CTRL_STATUS;
          strobe_next         = 2'd3;
        end
        default: begin
          res_next.ctrl_lines = '0;
          strobe_next         = 2'd0;
          poll_counter_next   = pc_inc[7:0];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      strobe_step    <= '0;
      register_index <= '0;
      poll_counter   <= '0;
      word_counter   <= '0;
      sector_latch   <= '0;
      head_latch     <= '0;
      cyl_low_latch  <= '0;
      cyl_high_latch <= '0;
      res_valid      <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      strobe_step    <= strobe_next;
      register_index <= register_index_next;
      poll_counter   <= poll_counter_next;
      word_counter   <= word_counter_next;
      sector_latch   <= sector_latch_next;
      head_latch     <= head_latch_next;
      cyl_low_latch  <= cyl_low_latch_next;
      cyl_high_latch <= cyl_high_latch_next;
      res_valid      <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign result.valid        = res_valid;
  assign result.ctrl_lines   = res.ctrl_lines;
  assign result.drive_data   = res.drive_data;
  assign result.drive_enable = res.drive_enable;
  assign result.word         = res.word;
  assign result.word_valid   = res.word_valid;
  assign result.word_last    = res.word_last;
  assign result.busy_res     = res.busy_res;
  assign result.done_res     = res.done_res;
  assign result.status       = res.status;

  `IPSR_ASSERT_IMP(a_done_not_busy, clk, rst, res_valid && res.done_res, !res.busy_res)
  `IPSR_ASSERT_IMP(a_status_on_done, clk, rst, res_valid && (res.status != ipsr_pkg::ST_OK),
                   res.done_res)
  `IPSR_ASSERT_NXT(a_word_strobe, clk, rst,
                   accept && (phase == PH_RD_DATA) && (strobe_step == 2'd1),
                   res_valid && res.word_valid)
  `IPSR_ASSERT_IMP(a_reg_index_range, clk, rst, 1'b1, register_index <= 3'd4)

endmodule
